@@ design/mlt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlt_pkg: motion light timer shared definitions
// Register indexes, field widths and counter limits.
// ----------------------------------------------------------------------------
package mlt_pkg;

	localparam int unsigned CNT_W  = 12;
	localparam int unsigned SECS_W = 10;
	localparam int unsigned IDX_W  = 3;
	localparam int unsigned CFG_W  = 12;

	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [SECS_W-1:0] secs_t;
	typedef logic [IDX_W-1:0]  cfg_idx_t;
	typedef logic [CFG_W-1:0]  cfg_data_t;

	localparam cnt_t CNT_MAX = '1;

	localparam cfg_idx_t REG_PIR_LOCKOUT = 3'd0;
	localparam cfg_idx_t REG_MS_PER_SEC  = 3'd1;
	localparam cfg_idx_t REG_PRESET_S    = 3'd2;
	localparam cfg_idx_t REG_PRESET_M    = 3'd3;
	localparam cfg_idx_t REG_PRESET_L    = 3'd4;

	localparam cnt_t  RST_PIR_LOCKOUT = 12'd500;
	localparam cnt_t  RST_MS_PER_SEC  = 12'd1000;
	localparam secs_t RST_PRESET_S    = 10'd30;
	localparam secs_t RST_PRESET_M    = 10'd60;
	localparam secs_t RST_PRESET_L    = 10'd300;
	localparam secs_t RST_HOLD        = 10'd30;

endpackage

@@ design/mlt_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlt_tick_if / mlt_result_if: motion light timer channels
// Valid/ready channels for tick items and result items.
// ----------------------------------------------------------------------------
interface mlt_tick_if;
	logic valid;
	logic ready;
	logic pir_level;
	logic btn_on;
	logic btn_timer;
	logic btn_short;
	logic btn_mid;
	logic btn_long;
	logic btn_off;

	modport source (output valid, pir_level, btn_on, btn_timer, btn_short, btn_mid,
		btn_long, btn_off, input ready);
	modport sink (input valid, pir_level, btn_on, btn_timer, btn_short, btn_mid,
		btn_long, btn_off, output ready);
endinterface

interface mlt_result_if
	import mlt_pkg::*;
;
	logic  valid;
	logic  ready;
	logic  relay_on;
	logic  timer_active;
	secs_t seconds_left;
	logic  motion_seen;
	logic  beep;
	logic  second_elapsed;

	modport source (output valid, relay_on, timer_active, seconds_left, motion_seen,
		beep, second_elapsed, input ready);
	modport sink (input valid, relay_on, timer_active, seconds_left, motion_seen,
		beep, second_elapsed, output ready);
endinterface

@@ design/motion_light_timer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motion_light_timer: occupancy light relay timer
// One tick item in (sensor level and six buttons), one result item out per
// tick: relay drive, mode, seconds left, held motion, beep and second strobe.
//
// Usage: send one item per millisecond tick on the tick channel; each item
// yields exactly one item on the result channel, in order. Configuration
// (lockout, ticks per second, three presets) is written through cfg_we /
// cfg_index / cfg_wdata; the user must write it only while no item is in
// flight, which the block does not enforce; unknown indexes are ignored.
// Path: the tick item passes the input register, then the result register;
// while the result is not taken, the item waits in the input register.
// Throughput: one item per cycle while results are taken; the whole state
// update is one pass of counter compares and selects between the two.
// Reset: timer mode, relay off, hold and time left 30 s, counters cleared,
// registers at their defaults, both stages empty.
// Stall: while the result is not taken, the input register holds its item
// and tick.ready drops once both stages are full; nothing is lost.
// ----------------------------------------------------------------------------
module motion_light_timer
	import mlt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	mlt_tick_if.sink  tick,
	mlt_result_if.source result,
	input  logic      cfg_we,
	input  cfg_idx_t  cfg_index,
	input  cfg_data_t cfg_wdata
);

	// configuration
	cnt_t  lockout_q, mps_q;
	secs_t preset_s_q, preset_m_q, preset_l_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lockout_q  <= RST_PIR_LOCKOUT;
			mps_q      <= RST_MS_PER_SEC;
			preset_s_q <= RST_PRESET_S;
			preset_m_q <= RST_PRESET_M;
			preset_l_q <= RST_PRESET_L;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PIR_LOCKOUT: lockout_q  <= cfg_wdata;
				REG_MS_PER_SEC:  mps_q      <= cfg_wdata;
				REG_PRESET_S:    preset_s_q <= cfg_wdata[SECS_W-1:0];
				REG_PRESET_M:    preset_m_q <= cfg_wdata[SECS_W-1:0];
				REG_PRESET_L:    preset_l_q <= cfg_wdata[SECS_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	logic valid_s1;
	logic pir_s1, on_s1, tmr_s1, short_s1, mid_s1, long_s1, off_s1;
	logic adv_s1;

	assign adv_s1     = valid_s1 && (!result.valid || result.ready);
	assign tick.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			pir_s1   <= tick.pir_level;
			on_s1    <= tick.btn_on;
			tmr_s1   <= tick.btn_timer;
			short_s1 <= tick.btn_short;
			mid_s1   <= tick.btn_mid;
			long_s1  <= tick.btn_long;
			off_s1   <= tick.btn_off;
		end
	end

	// state
	logic  held_q, mode_q, relay_q;
	cnt_t  lock_cnt_q, upd_cnt_q;
	secs_t hold_q, left_q;

	logic  pir_fire, held_n, upd_fire, mode_n, relay_n, beep_n;
	secs_t hold_n, left_a, left_b, left_n;
	cnt_t  lock_cnt_n, upd_cnt_n;

	always_comb begin
		pir_fire = (lock_cnt_q >= lockout_q) && (pir_s1 != held_q);
		held_n   = pir_fire ? pir_s1 : held_q;
		beep_n   = on_s1 | tmr_s1 | short_s1 | mid_s1 | long_s1 | off_s1;

		priority if (long_s1) hold_n = preset_l_q;
		else if (mid_s1)      hold_n = preset_m_q;
		else if (short_s1)    hold_n = preset_s_q;
		else                  hold_n = hold_q;

		left_a = ((short_s1 | mid_s1 | long_s1) && mode_q) ? hold_n : left_q;
		left_b = tmr_s1 ? hold_n : left_a;

		priority if (off_s1) mode_n = 1'b0;
		else if (tmr_s1)     mode_n = 1'b1;
		else if (on_s1)      mode_n = 1'b0;
		else                 mode_n = mode_q;

		priority if (off_s1) relay_n = 1'b0;
		else if (on_s1)      relay_n = 1'b1;
		else                 relay_n = relay_q;

		upd_fire = mode_n && (upd_cnt_q >= mps_q);
		left_n   = left_b;
		if (upd_fire) begin
			priority if (held_n)      left_n = hold_n;
			else if (left_b != '0)    left_n = left_b - secs_t'(1);
			else                      left_n = '0;
			relay_n = (left_n != '0);
		end

		lock_cnt_n = pir_fire ? cnt_t'(1) :
			((lock_cnt_q == CNT_MAX) ? CNT_MAX : lock_cnt_q + cnt_t'(1));
		upd_cnt_n  = upd_fire ? cnt_t'(1) :
			((upd_cnt_q == CNT_MAX) ? CNT_MAX : upd_cnt_q + cnt_t'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q     <= 1'b0;
			mode_q     <= 1'b1;
			relay_q    <= 1'b0;
			lock_cnt_q <= '0;
			upd_cnt_q  <= '0;
			hold_q     <= RST_HOLD;
			left_q     <= RST_HOLD;
		end else if (adv_s1) begin
			held_q     <= held_n;
			mode_q     <= mode_n;
			relay_q    <= relay_n;
			lock_cnt_q <= lock_cnt_n;
			upd_cnt_q  <= upd_cnt_n;
			hold_q     <= hold_n;
			left_q     <= left_n;
		end
	end

	// result register
	logic valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || result.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			result.relay_on       <= relay_n;
			result.timer_active   <= mode_n;
			result.seconds_left   <= left_n;
			result.motion_seen    <= held_n;
			result.beep           <= beep_n;
			result.second_elapsed <= upd_fire;
		end
	end

	assign result.valid = valid_s2;

	// checks
	a_strobe_in_timer: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.second_elapsed |-> result.timer_active)
		else $error("second strobe outside timer mode");

	a_relay_follows: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.second_elapsed |->
			(result.relay_on == (result.seconds_left != '0)))
		else $error("relay does not follow time left on update");

	a_motion_reload: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.second_elapsed && result.motion_seen |->
			(result.seconds_left == hold_q))
		else $error("motion update did not reload hold time");

	a_state_matches: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.timer_active == mode_q && result.motion_seen == held_q))
		else $error("result out of step with state");

endmodule
